// ----- hdl/dqir_pkg.sv -----
// Package for the deque with indexed remove: sizes, codes and shared types.
package dqir_pkg;

   // Storage geometry.
   localparam int CAPACITY   = 16;
   localparam int WORD_WIDTH = 32;
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int INDEX_W    = $clog2(CAPACITY);

   // Fixed widths of the item fields.
   localparam int OPCODE_W   = 3;
   localparam int DATA_W     = 32;
   localparam int POSITION_W = 4;
   localparam int ENTRY_CNT_W = 5;
   localparam int STATUS_W   = 2;

   // Operation codes.
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_CLEAR      = 3'd5
   } opcode_type;

   // Status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // One registered command handed to the store.
   typedef struct packed {
      logic                  valid;
      logic [OPCODE_W-1:0]   opcode;
      logic [DATA_W-1:0]     push_value;
      logic [POSITION_W-1:0] position;
   } dqir_cmd_type;

   // Result of one command, as it leaves on the result ports.
   typedef struct packed {
      logic [DATA_W-1:0]      taken_value;
      logic [DATA_W-1:0]      front_value;
      logic [DATA_W-1:0]      back_value;
      logic [ENTRY_CNT_W-1:0] entry_count;
      status_type             status;
   } dqir_result_type;

   // Stored word to output field width (zero extension or truncation).
   function automatic logic [DATA_W-1:0] word_to_data(input word_type w);
      return DATA_W'(w);
   endfunction

endpackage

// ----- hdl/deque_with_indexed_remove_top.sv -----
// Top level of the deque with indexed remove: item register, store, result register.
//
// A fixed-capacity ordered list of 16 signed 32-bit words with push and pop at
// either end, removal at a position counted from the front, and clear. An item
// is taken at every clock edge where start is high and busy is low; busy is
// high only in the first cycle after reset, so one item can be given in every
// cycle. Each item yields exactly one result, shown on the rsp_ ports for one
// cycle with rsp_valid high, after the item has passed through the item
// register and then through the store's shift logic into the result
// register. Results come in item order and cannot be held off, so
// the receiver must take them as they appear. A failed operation (status
// empty, full or position out of range) leaves the list unchanged and reports
// a taken word of zero; front and back words read zero on an empty list.
module deque_with_indexed_remove_top import dqir_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic signed [DATA_W-1:0] req_push_value,
   input  logic [POSITION_W-1:0]  req_position,
   output logic                   rsp_valid,
   output logic signed [DATA_W-1:0] rsp_taken_value,
   output logic signed [DATA_W-1:0] rsp_front_value,
   output logic signed [DATA_W-1:0] rsp_back_value,
   output logic [ENTRY_CNT_W-1:0] rsp_entry_count,
   output logic [STATUS_W-1:0]    rsp_status
);

   logic            busy_ff;
   dqir_cmd_type    cmd_ff;
   dqir_cmd_type    cmd_in;
   dqir_result_type result;
   dqir_result_type rsp_ff;
   logic            rsp_valid_ff;

   // Capture the item on acceptance.
   assign cmd_in.valid      = start && !busy_ff;
   assign cmd_in.opcode     = req_opcode;
   assign cmd_in.push_value = req_push_value;
   assign cmd_in.position   = req_position;

   // Busy only while coming out of reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Item register.
   always_ff @(posedge clock) begin
      cmd_ff.opcode     <= cmd_in.opcode;
      cmd_ff.push_value <= cmd_in.push_value;
      cmd_ff.position   <= cmd_in.position;
      if (reset) begin
         cmd_ff.valid <= 1'b0;
      end else begin
         cmd_ff.valid <= cmd_in.valid;
      end
   end

   dqir_store u_store (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_ff),
      .result (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      rsp_ff <= result;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd_ff.valid;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_taken_value = rsp_ff.taken_value;
   assign rsp_front_value = rsp_ff.front_value;
   assign rsp_back_value  = rsp_ff.back_value;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_status      = rsp_ff.status;

endmodule

// ----- hdl/dqir_store.sv -----
// Ordered register array with its count, updated by one command per cycle.
module dqir_store import dqir_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  dqir_cmd_type    cmd,
   output dqir_result_type result
);

   word_type             entries_ff [CAPACITY];
   word_type             entries_in [CAPACITY];
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;

   // Neighbour views of the array for the two shift directions.
   word_type             shift_down [CAPACITY];
   word_type             shift_up   [CAPACITY];
   word_type             value;

   logic                 list_empty;
   logic                 is_full;
   logic                 in_range;
   logic [COUNT_W-1:0]   last_idx;
   logic [COUNT_W-1:0]   back_idx;
   logic [INDEX_W-1:0]   pos_idx;
   logic [DATA_W-1:0]    taken_word;
   status_type           op_status;

   assign value      = WORD_WIDTH'(cmd.push_value);
   assign list_empty = (count_ff == '0);
   assign is_full    = (count_ff == COUNT_W'(CAPACITY));
   assign in_range   = (32'(cmd.position) < 32'(count_ff));
   assign pos_idx    = INDEX_W'(cmd.position);
   assign last_idx   = count_ff - 1'b1;

   // Each slot sees its lower and upper neighbour.
   always_comb begin
      shift_down[0] = value;
      for (int i = 1; i < CAPACITY; i++) begin
         shift_down[i] = entries_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         shift_up[i] = entries_ff[i+1];
      end
      shift_up[CAPACITY-1] = entries_ff[CAPACITY-1];
   end

   // Next array contents, count, taken word and status.
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      taken_word = '0;
      op_status  = ST_OK;
      if (cmd.valid) begin
         unique case (cmd.opcode)
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  op_status = ST_FULL;
               end else begin
                  entries_in = shift_down;
                  count_in   = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  op_status = ST_FULL;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (COUNT_W'(i) == count_ff) begin
                        entries_in[i] = value;
                     end
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (list_empty) begin
                  op_status = ST_EMPTY;
               end else begin
                  taken_word = word_to_data(entries_ff[0]);
                  entries_in = shift_up;
                  count_in   = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (list_empty) begin
                  op_status = ST_EMPTY;
               end else begin
                  taken_word = word_to_data(entries_ff[last_idx[INDEX_W-1:0]]);
                  count_in   = count_ff - 1'b1;
               end
            end
            OP_REMOVE: begin
               if (list_empty) begin
                  op_status = ST_EMPTY;
               end else if (!in_range) begin
                  op_status = ST_RANGE;
               end else begin
                  taken_word = word_to_data(entries_ff[pos_idx]);
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (INDEX_W'(i) >= pos_idx) begin
                        entries_in[i] = shift_up[i];
                     end
                  end
                  count_in = count_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               // Unused codes leave the list as it is.
            end
         endcase
      end
   end

   // Taken word, status, and front, back and count after the operation.
   always_comb begin
      back_idx           = count_in - 1'b1;
      result.taken_value = taken_word;
      result.status      = op_status;
      result.entry_count = ENTRY_CNT_W'(count_in);
      if (count_in == '0) begin
         result.front_value = '0;
         result.back_value  = '0;
      end else begin
         result.front_value = word_to_data(entries_in[0]);
         result.back_value  = word_to_data(entries_in[back_idx[INDEX_W-1:0]]);
      end
   end

   // Array words carry no reset; the count does.
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/dqir_checker.sv -----
// Port-level checks for the deque with indexed remove, bound to the top level.
module dqir_checker import dqir_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [DATA_W-1:0]      rsp_taken_value,
   input logic [DATA_W-1:0]      rsp_front_value,
   input logic [DATA_W-1:0]      rsp_back_value,
   input logic [ENTRY_CNT_W-1:0] rsp_entry_count,
   input logic [STATUS_W-1:0]    rsp_status
);

   // Every accepted item gives a result, after the item and result registers.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_valid)
      else $error("accepted item produced no result");

   // No result appears without a matching accepted item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching item");

   // An empty list reports zero front and back words.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == '0 |-> rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty list reports non-zero ends");

   // A failed operation takes no word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_taken_value == '0)
      else $error("failed operation returned a word");

   // Full is only reported at capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == ENTRY_CNT_W'(CAPACITY))
      else $error("full status below capacity");

endmodule

bind deque_with_indexed_remove_top dqir_checker u_dqir_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_taken_value (rsp_taken_value),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_status      (rsp_status)
);

// ----- sim/tb.sv -----
// Self-checking testbench for the deque with indexed remove, directed and random items.
`timescale 1ns / 1ps

module tb;
   import dqir_pkg::*;

   // Opcodes outside the defined set, which the block must ignore.
   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int RANDOM_ITEMS = 700;
   localparam int SETTLE_CYCLES = 8;

   // One item waiting to be driven; hold_for_idle makes the sender wait for an empty pipe.
   typedef struct {
      logic [OPCODE_W-1:0]   opcode;
      logic [DATA_W-1:0]     push_value;
      logic [POSITION_W-1:0] position;
      bit                    hold_for_idle;
   } deque_op_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [OPCODE_W-1:0]           req_opcode = '0;
   logic signed [DATA_W-1:0]      req_push_value = '0;
   logic [POSITION_W-1:0]         req_position = '0;
   logic                          rsp_valid;
   logic signed [DATA_W-1:0]      rsp_taken_value;
   logic signed [DATA_W-1:0]      rsp_front_value;
   logic signed [DATA_W-1:0]      rsp_back_value;
   logic [ENTRY_CNT_W-1:0]        rsp_entry_count;
   logic [STATUS_W-1:0]           rsp_status;

   deque_op_type    pending_ops[$];
   dqir_result_type awaited_results[$];

   // Shadow copy of the list, slot 0 at the front.
   word_type               list_words[CAPACITY];
   logic [COUNT_W-1:0]     list_count = '0;

   int errors = 0;
   int items_taken = 0;
   int results_checked = 0;
   int status_tally[4] = '{0, 0, 0, 0};
   int gap_left = 0;
   int burst_left = 1;

   deque_with_indexed_remove_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_push_value  (req_push_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_taken_value (rsp_taken_value),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   always #4 clock = ~clock;

   // Applies one item to the shadow list and returns the result the block should give.
   function automatic dqir_result_type deque_apply(input deque_op_type op);
      dqir_result_type res;
      word_type        taken;
      status_type      st;
      int              i;
      taken = '0;
      st    = ST_OK;
      case (op.opcode)
         OP_PUSH_FRONT: begin
            if (list_count >= CAPACITY) begin
               st = ST_FULL;
            end else begin
               for (i = int'(list_count); i > 0; i--) list_words[i] = list_words[i-1];
               list_words[0] = op.push_value;
               list_count++;
            end
         end
         OP_PUSH_BACK: begin
            if (list_count >= CAPACITY) begin
               st = ST_FULL;
            end else begin
               list_words[list_count] = op.push_value;
               list_count++;
            end
         end
         OP_POP_FRONT, OP_REMOVE: begin
            if (list_count == 0) begin
               st = ST_EMPTY;
            end else if (op.opcode == OP_REMOVE && op.position >= list_count) begin
               st = ST_RANGE;
            end else begin
               // A pop at the front is a removal at position zero.
               i = (op.opcode == OP_REMOVE) ? int'(op.position) : 0;
               taken = list_words[i];
               for (; i + 1 < int'(list_count); i++) list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         OP_POP_BACK: begin
            if (list_count == 0) begin
               st = ST_EMPTY;
            end else begin
               taken = list_words[list_count - 1];
               list_count--;
            end
         end
         OP_CLEAR: begin
            list_count = '0;
         end
         default: begin
         end
      endcase
      res.taken_value = taken;
      res.front_value = '0;
      res.back_value  = '0;
      if (list_count != 0) begin
         res.front_value = list_words[0];
         res.back_value  = list_words[list_count - 1];
      end
      res.entry_count = ENTRY_CNT_W'(list_count);
      res.status      = st;
      status_tally[st]++;
      return res;
   endfunction

   // Word for a push: extremes and small values mixed in with full-range words.
   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(input logic [OPCODE_W-1:0] opc, input logic [DATA_W-1:0] value,
                           input logic [POSITION_W-1:0] pos, input bit hold);
      deque_op_type op;
      op.opcode        = opc;
      op.push_value    = value;
      op.position      = pos;
      op.hold_for_idle = hold;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   // Sender: items go out in bursts of random length separated by random gaps.
   always @(posedge clock) begin : op_driver
      deque_op_type op;
      bit           taken_now;
      if (reset) begin
         start      <= 1'b0;
         list_count =  '0;
         gap_left   =  0;
         burst_left =  $urandom_range(1, 24);
      end else begin
         taken_now = start && !busy;
         if (taken_now) begin
            op.opcode        = req_opcode;
            op.push_value    = req_push_value;
            op.position      = req_position;
            op.hold_for_idle = 1'b0;
            awaited_results.insert(awaited_results.size(), deque_apply(op));
            items_taken++;
         end
         if (start && !taken_now) begin
            // The block is not ready yet, so the same item stays on the ports.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_ops.size() > 0 &&
                      !(pending_ops[0].hold_for_idle &&
                        (awaited_results.size() != 0 || rsp_valid))) begin
            op = pending_ops[0];
            pending_ops.delete(0);
            req_opcode     <= op.opcode;
            req_push_value <= op.push_value;
            req_position   <= op.position;
            start          <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Receiver: every strobed result is compared with the oldest expectation.
   always @(posedge clock) begin : result_monitor
      dqir_result_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
         end else begin
            want = awaited_results[0];
            awaited_results.delete(0);
            results_checked++;
            if (rsp_taken_value !== want.taken_value) begin
               $error("taken_value: expected %0d, got %0d", $signed(want.taken_value),
                      rsp_taken_value);
               errors++;
            end
            if (rsp_front_value !== want.front_value) begin
               $error("front_value: expected %0d, got %0d", $signed(want.front_value),
                      rsp_front_value);
               errors++;
            end
            if (rsp_back_value !== want.back_value) begin
               $error("back_value: expected %0d, got %0d", $signed(want.back_value),
                      rsp_back_value);
               errors++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_entry_count);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // Stimulus, end of run and verdict.
   initial begin : stimulus
      int                    made;
      int                    phase;
      int                    phase_len;
      int                    roll;
      logic [OPCODE_W-1:0]   opc;

      // Directed part: empty-list failures, ignored opcodes, extremes and removals.
      queue_op(OP_POP_FRONT,  32'h0,         4'd0,  1'b0);
      queue_op(OP_POP_BACK,   32'hFFFF_FFFF, 4'd15, 1'b0);
      queue_op(OP_REMOVE,     32'h0,         4'd0,  1'b0);
      queue_op(OP_CLEAR,      32'h0,         4'd0,  1'b0);
      queue_op(OP_SPARE_6,    32'hFFFF_FFFF, 4'd15, 1'b0);
      queue_op(OP_SPARE_7,    32'h1234_5678, 4'd7,  1'b0);
      queue_op(OP_PUSH_FRONT, 32'h7FFF_FFFF, 4'd0,  1'b0);
      queue_op(OP_PUSH_BACK,  32'h8000_0000, 4'd0,  1'b0);
      queue_op(OP_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0,  1'b0);
      queue_op(OP_REMOVE,     32'h0,         4'd3,  1'b0);
      queue_op(OP_REMOVE,     32'h0,         4'd15, 1'b0);
      queue_op(OP_REMOVE,     32'h0,         4'd1,  1'b0);
      queue_op(OP_PUSH_BACK,  32'h0,         4'd0,  1'b0);
      queue_op(OP_REMOVE,     32'h0,         4'd2,  1'b0);
      queue_op(OP_POP_BACK,   32'h0,         4'd0,  1'b0);
      queue_op(OP_POP_FRONT,  32'h0,         4'd0,  1'b0);
      queue_op(OP_PUSH_BACK,  32'h0001_2345, 4'd0,  1'b0);
      queue_op(OP_REMOVE,     32'h0,         4'd0,  1'b0);
      queue_op(OP_PUSH_FRONT, 32'h5,         4'd0,  1'b0);
      queue_op(OP_PUSH_BACK,  32'h6,         4'd0,  1'b0);
      queue_op(OP_SPARE_6,    32'h0,         4'd0,  1'b0);
      queue_op(OP_CLEAR,      32'h0,         4'd0,  1'b0);
      queue_op(OP_POP_BACK,   32'h0,         4'd0,  1'b0);

      // Random part in phases that lean towards filling, draining or a mixture,
      // so that the list regularly reaches both full and empty.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         phase     = $urandom_range(0, 2);
         phase_len = $urandom_range(20, 60);
         for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (phase == 0) begin
               opc = (roll < 40) ? OP_PUSH_FRONT : (roll < 80) ? OP_PUSH_BACK :
                     (roll < 86) ? OP_POP_FRONT  : (roll < 90) ? OP_POP_BACK  :
                     (roll < 96) ? OP_REMOVE     : (roll < 98) ? OP_CLEAR     : OP_SPARE_6;
            end else if (phase == 1) begin
               opc = (roll < 10) ? OP_PUSH_FRONT : (roll < 20) ? OP_PUSH_BACK :
                     (roll < 45) ? OP_POP_FRONT  : (roll < 65) ? OP_POP_BACK  :
                     (roll < 95) ? OP_REMOVE     : (roll < 97) ? OP_CLEAR     : OP_SPARE_7;
            end else begin
               opc = (roll < 20) ? OP_PUSH_FRONT : (roll < 40) ? OP_PUSH_BACK :
                     (roll < 55) ? OP_POP_FRONT  : (roll < 70) ? OP_POP_BACK  :
                     (roll < 90) ? OP_REMOVE     : (roll < 94) ? OP_CLEAR     :
                     (roll < 97) ? OP_SPARE_6    : OP_SPARE_7;
            end
            queue_op(opc, pick_word(),
                     POSITION_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) :
                                                               $urandom_range(0, 3)),
                     made == 0 || $urandom_range(0, 99) == 0);
            made++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item has gone out and every result has been checked.
      do begin
         @(negedge clock);
      end while (pending_ops.size() != 0 || start || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Ran %0d items: %0d ok, %0d on an empty list, %0d on a full list, %0d out of range.",
               items_taken, status_tally[ST_OK], status_tally[ST_EMPTY],
               status_tally[ST_FULL], status_tally[ST_RANGE]);
      $display("%0d results compared, %0d field mismatches.", results_checked, errors);
      if (errors == 0 && awaited_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("Run timed out with %0d results outstanding.", awaited_results.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
